// ----- design/ffpa_pkg.sv -----
// Shared types, widths and defaults for the first-fit partition allocator.
package ffpa_pkg;

  localparam int DEF_NUM_SLOTS = 16;
  localparam int DEF_MAX_BYTES = 1024;

  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 11;
  localparam int LEFT_W   = 10;
  localparam int INT_W    = 14;
  localparam int FREE_W   = 15;
  localparam int REF_W    = 16;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
  localparam logic [LEFT_W-1:0] LEFT_MAX  = '1;
  localparam logic [INT_W-1:0]  INT_MAX   = '1;
  localparam logic [FREE_W-1:0] FREE_MAX  = '1;
  localparam logic [REF_W-1:0]  REF_MAX   = '1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] block_slot;
    logic [SIZE_W-1:0] block_bytes;
    logic [SIZE_W-1:0] request_bytes;
  } in_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] chosen_slot;
    logic [LEFT_W-1:0] leftover_bytes;
    logic [INT_W-1:0]  internal_total;
    logic [FREE_W-1:0] free_total;
    logic [REF_W-1:0]  refused_count;
  } out_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// ----- design/first_fit_partition_allocator.sv -----
// Top level of the first-fit fixed-partition allocator.
// Each request produces exactly one result. Load and allocate requests take the same path:
// a load state that writes the partition table for loads only, then a first-fit scan that
// reads the partition size memory one entry per cycle and also rebuilds the free total.
// The scan covers blocks_in_use partitions (capped at NUM_SLOTS); a final state then
// registers the result, and the controller returns to idle to accept the next request.
// The last step waits while the output register still holds a result that has not been
// taken. A new request is accepted while the previous result still waits in the output
// register. Reset clears the table at once through per-partition loaded bits, so no
// clearing pass is needed.
module first_fit_partition_allocator #(
  parameter int NUM_SLOTS = ffpa_pkg::DEF_NUM_SLOTS,
  parameter int MAX_BYTES = ffpa_pkg::DEF_MAX_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ffpa_pkg::in_t              in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ffpa_pkg::out_t             out_item,
  input  logic                       cfg_we,
  input  logic [ffpa_pkg::CFG_W-1:0] cfg_wdata
);
  import ffpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffpa_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- design/ffpa_ctrl.sv -----
// Controller state machine sequencing load, table scan and result hand-off.
module ffpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ffpa_pkg::stat_t stat,
  output ffpa_pkg::cmd_t  cmd
);
  import ffpa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.write  = (stat.func == FUNC_LOAD);
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/ffpa_datapath.sv -----
// Datapath: partition size memory, used bits, scan evaluation, totals and output register.
module ffpa_datapath #(
  parameter int NUM_SLOTS = ffpa_pkg::DEF_NUM_SLOTS,
  parameter int MAX_BYTES = ffpa_pkg::DEF_MAX_BYTES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ffpa_pkg::in_t                  in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ffpa_pkg::out_t                 out_item,
  input  logic                           cfg_we,
  input  logic [ffpa_pkg::CFG_W-1:0]     cfg_wdata,
  input  ffpa_pkg::cmd_t                 cmd,
  output ffpa_pkg::stat_t                stat
);
  import ffpa_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic [SIZE_W-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] loaded;
  logic [NUM_SLOTS-1:0] used;

  logic [CFG_W-1:0]  blocks_in_use;
  in_t               item;
  logic [CW-1:0]     scan_n;
  logic [CW-1:0]     issue_idx;
  logic [SW-1:0]     rd_idx;
  logic              rd_live;
  logic [SIZE_W-1:0] rd_size;
  logic              rd_loaded;
  logic              found;
  logic [SW-1:0]     chosen;
  logic [LEFT_W-1:0] left;
  logic [FREE_W-1:0] free_acc;
  logic [INT_W-1:0]  internal_sum;
  logic [REF_W-1:0]  refused_sum;

  logic [31:0]       slot_wide;
  logic [SW-1:0]     wr_addr;
  logic              slot_ok;
  logic [SIZE_W-1:0] bytes_clamped;
  logic              rd_en;
  logic [SIZE_W-1:0] cur_size;
  logic              cur_used;
  logic              fit;
  logic [SIZE_W-1:0] diff;
  logic [FREE_W:0]   free_sum_w;
  logic [INT_W:0]    int_sum_w;
  logic [INT_W-1:0]  internal_next;
  logic [REF_W-1:0]  refused_next;
  logic              grant;

  assign slot_wide     = 32'(item.block_slot);
  assign wr_addr       = slot_wide[SW-1:0];
  assign slot_ok       = (slot_wide < NUM_SLOTS);
  assign bytes_clamped = (32'(item.block_bytes) > MAX_BYTES) ? SIZE_W'(MAX_BYTES)
                                                             : item.block_bytes;
  assign rd_en         = cmd.scan && (issue_idx < scan_n);

  assign cur_size   = rd_loaded ? rd_size : '0;
  assign cur_used   = used[rd_idx];
  assign fit        = rd_live && !found && (item.func == FUNC_ALLOC) && !cur_used
                      && (cur_size != '0) && (cur_size >= item.request_bytes);
  assign diff       = cur_size - item.request_bytes;
  assign free_sum_w = {1'b0, free_acc} + (FREE_W + 1)'(cur_size);
  assign int_sum_w  = {1'b0, internal_sum} + (INT_W + 1)'(left);
  assign grant      = found && (item.func == FUNC_ALLOC);

  always_comb begin
    internal_next = internal_sum;
    refused_next  = refused_sum;
    if (item.func == FUNC_ALLOC) begin
      if (found) begin
        internal_next = (int_sum_w > (INT_W + 1)'(INT_MAX)) ? INT_MAX : int_sum_w[INT_W-1:0];
      end else if (refused_sum != REF_MAX) begin
        refused_next = refused_sum + 1'b1;
      end
    end
  end

  assign stat.func      = item.func;
  assign stat.scan_done = (issue_idx == scan_n) && !rd_live;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) begin
      mem[wr_addr] <= bytes_clamped;
    end
    if (rd_en) begin
      rd_size <= mem[issue_idx[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item   <= in_item;
      scan_n <= (32'(blocks_in_use) > NUM_SLOTS) ? CW'(NUM_SLOTS) : CW'(blocks_in_use);
    end
    if (rd_en) begin
      rd_idx    <= issue_idx[SW-1:0];
      rd_loaded <= loaded[issue_idx[SW-1:0]];
    end
    if (fit) begin
      chosen <= rd_idx;
      left   <= (diff > SIZE_W'(LEFT_MAX)) ? LEFT_MAX : diff[LEFT_W-1:0];
    end
    if (cmd.finish) begin
      out_item.granted        <= grant;
      out_item.chosen_slot    <= grant ? SLOT_W'(32'(chosen)) : '0;
      out_item.leftover_bytes <= grant ? left : '0;
      out_item.internal_total <= internal_next;
      out_item.free_total     <= free_acc;
      out_item.refused_count  <= refused_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= CFG_RESET;
      loaded        <= '0;
      used          <= '0;
      issue_idx     <= '0;
      rd_live       <= 1'b0;
      found         <= 1'b0;
      free_acc      <= '0;
      internal_sum  <= '0;
      refused_sum   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        blocks_in_use <= cfg_wdata;
      end
      if (cmd.capture) begin
        issue_idx <= '0;
        rd_live   <= 1'b0;
        found     <= 1'b0;
        free_acc  <= '0;
      end else begin
        rd_live <= rd_en;
        if (rd_en) begin
          issue_idx <= issue_idx + 1'b1;
        end
        if (fit) begin
          found <= 1'b1;
        end else if (rd_live && !cur_used) begin
          free_acc <= (free_sum_w > (FREE_W + 1)'(FREE_MAX)) ? FREE_MAX
                                                              : free_sum_w[FREE_W-1:0];
        end
      end
      if (cmd.write && slot_ok) begin
        loaded[wr_addr] <= 1'b1;
        used[wr_addr]   <= 1'b0;
      end
      if (cmd.finish && grant) begin
        used[chosen] <= 1'b1;
      end
      if (cmd.finish) begin
        internal_sum <= internal_next;
        refused_sum  <= refused_next;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten while occupied");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_live |-> (CW'(rd_idx) < scan_n))
    else $error("scan read beyond the scanned partitions");

  a_refusal_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.granted) |->
      (out_item.chosen_slot == '0 && out_item.leftover_bytes == '0))
    else $error("refused or load result carries a slot or leftover");

  a_internal_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (internal_sum >= $past(internal_sum)))
    else $error("internal fragmentation total decreased");

endmodule
